// ===== design/rls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rls_pkg;

   localparam int ORDER  = 4;
   localparam int DIM    = ORDER + 1;
   localparam int IDX_W  = $clog2(DIM);
   localparam int FILL_W = $clog2(ORDER + 1);

   localparam int SMP_W   = 24;
   localparam int LAM_W   = 16;
   localparam int FRAC    = 24;
   localparam int FX_W    = 48;
   localparam int HALF_W  = FX_W - FRAC;
   localparam int MPROD_W = 2 * (HALF_W + 1);
   localparam int PROD_W  = 52;
   localparam int ACC_W   = 56;
   localparam int DVD_W   = FX_W + FRAC;
   localparam int DVS_W   = ACC_W;
   localparam int ITER_W  = $clog2(DVD_W + 1);
   localparam int LAM_DVD_W = FX_W + LAM_W;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORGET   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COV = 1'd1;

   localparam logic [LAM_W-1:0] FORGET_RST   = 16'd65405;
   localparam logic [LAM_W-1:0] INIT_COV_RST = 16'd3000;

   localparam logic signed [FX_W-1:0] ONE_Q  = 48'sd16777216;
   localparam logic signed [FX_W-1:0] HI_LIM = 48'sd67108864;
   localparam logic [FX_W-1:0]        LOW_RND = 48'd8388608;
   localparam logic signed [PROD_W-1:0] MUL_CLAMP = {1'b0, 1'b1, 50'b0};
   localparam logic signed [FX_W-1:0]  MAX48 = {1'b0, {(FX_W-1){1'b1}}};
   localparam logic signed [FX_W-1:0]  MIN48 = {1'b1, {(FX_W-1){1'b0}}};
   localparam logic signed [SMP_W-1:0] MAX24 = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic signed [SMP_W-1:0] MIN24 = {1'b1, {(SMP_W-1){1'b0}}};

   localparam logic [ITER_W-1:0] GAIN_ITERS = ITER_W'(DVD_W);
   localparam logic [ITER_W-1:0] LAM_ITERS  = ITER_W'(LAM_DVD_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR_MAC,
      ST_ERR,
      ST_PX,
      ST_XTP,
      ST_DEN,
      ST_GAIN,
      ST_COEF,
      ST_EST_MAC,
      ST_EST,
      ST_PUPD_MUL,
      ST_PUPD_DIV,
      ST_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      MS_IDLE,
      MS_HH,
      MS_HL,
      MS_LH,
      MS_LL,
      MS_SUM
   } mul_step_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_RUN,
      DS_FIN
   } div_state_type;

   typedef struct packed {
      logic                     start;
      logic signed [FX_W-1:0]   a;
      logic signed [FX_W-1:0]   b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic              neg;
      logic              round_en;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [ITER_W-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic                   sat;
      logic signed [FX_W-1:0] quot;
   } div_rsp_type;

   function automatic logic ovf48(input logic signed [ACC_W-1:0] v);
      return (v > ACC_W'(MAX48)) || (v < ACC_W'(MIN48));
   endfunction

   function automatic logic signed [FX_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
      logic signed [FX_W-1:0] r;
      if (v > ACC_W'(MAX48)) begin
         r = MAX48;
      end else if (v < ACC_W'(MIN48)) begin
         r = MIN48;
      end else begin
         r = v[FX_W-1:0];
      end
      return r;
   endfunction

   function automatic logic ovf24(input logic signed [ACC_W-1:0] v);
      return (v > ACC_W'(MAX24)) || (v < ACC_W'(MIN24));
   endfunction

   function automatic logic signed [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
      logic signed [SMP_W-1:0] r;
      if (v > ACC_W'(MAX24)) begin
         r = MAX24;
      end else if (v < ACC_W'(MIN24)) begin
         r = MIN24;
      end else begin
         r = v[SMP_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/rls_fxmul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rls_fxmul import rls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   mul_step_type step_ff, step_in;

   logic signed [HALF_W-1:0]  ah_ff, bh_ff;
   logic [HALF_W-1:0]         al_ff, bl_ff;
   logic signed [HALF_W:0]    op_a, op_b;
   logic signed [MPROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0]  acc_ff;
   logic                      done_ff;
   logic signed [FX_W-1:0]    hi;
   logic                      hi_big, hi_neg;
   logic [FX_W-1:0]           low_sum;

   always_comb begin
      case (step_ff)
         MS_HH: begin
            op_a = {ah_ff[HALF_W-1], ah_ff};
            op_b = {bh_ff[HALF_W-1], bh_ff};
         end
         MS_HL: begin
            op_a = {ah_ff[HALF_W-1], ah_ff};
            op_b = {1'b0, bl_ff};
         end
         MS_LH: begin
            op_a = {bh_ff[HALF_W-1], bh_ff};
            op_b = {1'b0, al_ff};
         end
         MS_LL: begin
            op_a = {1'b0, al_ff};
            op_b = {1'b0, bl_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in = op_a * op_b;
      hi      = prod_ff[FX_W-1:0];
      hi_big  = hi > HI_LIM;
      hi_neg  = hi < -HI_LIM;
      low_sum = prod_ff[FX_W-1:0] + LOW_RND;
   end

   always_comb begin
      step_in = step_ff;
      case (step_ff)
         MS_IDLE: if (mul_req.start) step_in = MS_HH;
         MS_HH:   step_in = MS_HL;
         MS_HL:   step_in = (hi_big || hi_neg) ? MS_IDLE : MS_LH;
         MS_LH:   step_in = MS_LL;
         MS_LL:   step_in = MS_SUM;
         MS_SUM:  step_in = MS_IDLE;
         default: step_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= MS_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= (step_ff == MS_SUM) || ((step_ff == MS_HL) && (hi_big || hi_neg));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (step_ff)
         MS_IDLE: begin
            if (mul_req.start) begin
               ah_ff <= mul_req.a[FX_W-1:FRAC];
               al_ff <= mul_req.a[FRAC-1:0];
               bh_ff <= mul_req.b[FX_W-1:FRAC];
               bl_ff <= mul_req.b[FRAC-1:0];
            end
         end
         MS_HL: begin
            if (hi_big) begin
               acc_ff <= MUL_CLAMP;
            end else if (hi_neg) begin
               acc_ff <= -MUL_CLAMP;
            end else begin
               acc_ff <= PROD_W'(hi) <<< FRAC;
            end
         end
         MS_LH, MS_LL: acc_ff <= acc_ff + PROD_W'(prod_ff);
         MS_SUM:       acc_ff <= acc_ff + PROD_W'(low_sum[FX_W-1:FRAC]);
         default: ;
      endcase
   end

   assign mul_rsp.done   = done_ff;
   assign mul_rsp.result = acc_ff;

endmodule

`default_nettype wire

// ===== design/rls_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rls_div import rls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   div_state_type state_ff, state_in;

   logic [DVD_W-1:0]       dvd_ff;
   logic [DVS_W-1:0]       dvs_ff;
   logic [DVS_W-1:0]       rem_ff;
   logic [FX_W:0]          quo_ff;
   logic                   ovf_ff, neg_ff, rnd_ff, done_ff, sat_ff;
   logic [ITER_W-1:0]      cnt_ff;
   logic signed [FX_W-1:0] quot_ff;

   logic [DVS_W:0]   r_sh, r_diff;
   logic             bit_set;
   logic             rnd_up;
   logic [FX_W+1:0]  q_rnd, lim;
   logic             over;
   logic [FX_W-1:0]  q_mag;

   always_comb begin
      r_sh    = {rem_ff, dvd_ff[DVD_W-1]};
      r_diff  = r_sh - {1'b0, dvs_ff};
      bit_set = r_sh >= {1'b0, dvs_ff};
      rnd_up  = rnd_ff && ({1'b0, rem_ff, 1'b0} >= {2'b00, dvs_ff});
      q_rnd   = {1'b0, quo_ff} + (FX_W+2)'(rnd_up);
      lim     = neg_ff ? ((FX_W+2)'(1) << (FX_W-1)) : (((FX_W+2)'(1) << (FX_W-1)) - 1'b1);
      over    = ovf_ff || (q_rnd > lim);
      q_mag   = over ? lim[FX_W-1:0] : q_rnd[FX_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DS_IDLE: if (div_req.start) state_in = DS_RUN;
         DS_RUN:  if (cnt_ff == ITER_W'(1)) state_in = DS_FIN;
         DS_FIN:  state_in = DS_IDLE;
         default: state_in = DS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == DS_FIN);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DS_IDLE: begin
            if (div_req.start) begin
               dvd_ff <= div_req.dividend;
               dvs_ff <= div_req.divisor;
               cnt_ff <= div_req.iters;
               neg_ff <= div_req.neg;
               rnd_ff <= div_req.round_en;
               rem_ff <= '0;
               quo_ff <= '0;
               ovf_ff <= 1'b0;
            end
         end
         DS_RUN: begin
            rem_ff <= bit_set ? r_diff[DVS_W-1:0] : r_sh[DVS_W-1:0];
            quo_ff <= {quo_ff[FX_W-1:0], bit_set};
            ovf_ff <= ovf_ff | quo_ff[FX_W];
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         DS_FIN: begin
            sat_ff  <= over;
            quot_ff <= neg_ff ? -$signed(q_mag) : $signed(q_mag);
         end
         default: ;
      endcase
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.sat  = sat_ff;
   assign div_rsp.quot = quot_ff;

endmodule

`default_nettype wire

// ===== design/rls_sample_predictor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports     Beat content (lowest bit first)
// --------  --------  ----------------------------------------------------
// request   req_*     tdata: sample[23:0]; tuser: restart
// response  rsp_*     tdata: estimate[23:0], pred_error[47:24]; tuser: saturated
// config    csr_*     index 0 forget_factor, index 1 init_cov_diag (16 bit)
//
// Most of the work per item is in the bit-serial divider: 25 covariance divisions
// by lambda (64 steps each) and up to 5 gain divisions (72 steps each), plus 95
// products on a 25x25 multiplier.
// Request ready is high only while the sequencer is idle; a finished response
// waits in its output register and the next request is taken meanwhile.
// Reset is synchronous and restores registers, window, coefficients and covariance.

module rls_sample_predictor import rls_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SMP_W-1:0]     req_tdata,   // sample
   input  logic [0:0]           req_tuser,   // restart

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*SMP_W-1:0]   rsp_tdata,   // estimate, pred_error
   output logic [0:0]           rsp_tuser,   // saturated

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LAM_W-1:0]     csr_wdata
);

   seq_state_type state_ff, state_in;

   logic [LAM_W-1:0]        forget_ff, init_cov_ff, lam;
   logic signed [SMP_W-1:0] window_ff [ORDER];
   logic signed [SMP_W-1:0] window_in [ORDER];
   logic signed [SMP_W-1:0] win_base  [ORDER];
   logic [FILL_W-1:0]       fill_ff, fill_in, fill_base;
   logic signed [FX_W-1:0]  coef_ff [DIM];
   logic signed [FX_W-1:0]  cov_ff  [DIM][DIM];
   logic signed [FX_W-1:0]  px_ff   [DIM];
   logic signed [FX_W-1:0]  xtp_ff  [DIM];
   logic signed [FX_W-1:0]  gain_ff [DIM];
   logic signed [FX_W-1:0]  x_vec   [DIM];
   logic signed [SMP_W-1:0] sample_ff, err_ff, est_ff;
   logic signed [ACC_W-1:0] acc_ff, den_ff;
   logic signed [FX_W-1:0]  pdiff_ff;
   logic                    sat_ff, pend_ff;
   logic [IDX_W-1:0]        i_ff, j_ff, row_sel, col_sel, g_idx;
   logic                    rsp_tvalid_ff;
   logic [2*SMP_W-1:0]      rsp_tdata_ff;
   logic                    rsp_tuser_ff;

   logic                    req_fire, out_free, i_last, j_last, den_bad;
   logic signed [FX_W-1:0]  cov_rd, gain_rd, num;
   logic [FX_W-1:0]         num_mag;
   logic [LAM_DVD_W-1:0]    lam_dvd;
   logic signed [ACC_W-1:0] res_ext, sum, rnd_acc, err_full, p_sub, c_add;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   rls_fxmul u_fxmul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   rls_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_comb begin
      lam = (forget_ff == '0) ? LAM_W'(1) : forget_ff;
      x_vec[0] = ONE_Q;
      for (int k = 1; k < DIM; k++) begin
         x_vec[k] = {{(FX_W-SMP_W-4){window_ff[k-1][SMP_W-1]}}, window_ff[k-1], 4'b0000};
      end
      for (int k = 0; k < ORDER; k++) begin
         win_base[k] = req_tuser[0] ? '0 : window_ff[k];
      end
      fill_base = req_tuser[0] ? '0 : fill_ff;
      if (fill_base < FILL_W'(ORDER)) begin
         for (int k = 0; k < ORDER; k++) begin
            window_in[k] = (FILL_W'(k) == fill_base) ? $signed(req_tdata) : win_base[k];
         end
         fill_in = fill_base + 1'b1;
      end else begin
         for (int k = 0; k < ORDER - 1; k++) begin
            window_in[k] = win_base[k+1];
         end
         window_in[ORDER-1] = $signed(req_tdata);
         fill_in = fill_base;
      end
   end

   always_comb begin
      i_last  = (i_ff == IDX_W'(DIM - 1));
      j_last  = (j_ff == IDX_W'(DIM - 1));
      row_sel = (state_ff == ST_XTP) ? j_ff : i_ff;
      col_sel = (state_ff == ST_XTP) ? i_ff : j_ff;
      g_idx   = (state_ff == ST_PUPD_MUL) ? i_ff : j_ff;
      cov_rd  = cov_ff[row_sel][col_sel];
      gain_rd = gain_ff[g_idx];
      den_bad = den_ff[ACC_W-1] || (den_ff == '0);
      res_ext = ACC_W'(mul_rsp.result);
      sum     = acc_ff + res_ext;
      rnd_acc = (acc_ff + ACC_W'(8)) >>> 4;
      err_full = ACC_W'(sample_ff) - rnd_acc;
      p_sub   = ACC_W'(cov_rd) - res_ext;
      c_add   = ACC_W'(coef_ff[j_ff]) + res_ext;
      num     = (state_ff == ST_GAIN) ? px_ff[j_ff] : pdiff_ff;
      num_mag = num[FX_W-1] ? (~num + 1'b1) : num;
      lam_dvd = {num_mag, {LAM_W{1'b0}}} + LAM_DVD_W'(lam[LAM_W-1:1]);
   end

   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = coef_ff[j_ff];
      mul_req.b     = x_vec[j_ff];
      case (state_ff)
         ST_ERR_MAC, ST_EST_MAC: mul_req.start = !pend_ff;
         ST_PX, ST_XTP: begin
            mul_req.start = !pend_ff;
            mul_req.a     = cov_rd;
         end
         ST_DEN: begin
            mul_req.start = !pend_ff;
            mul_req.a     = xtp_ff[j_ff];
         end
         ST_COEF: begin
            mul_req.start = !pend_ff;
            mul_req.a     = gain_rd;
            mul_req.b     = {{(FX_W-SMP_W-4){err_ff[SMP_W-1]}}, err_ff, 4'b0000};
         end
         ST_PUPD_MUL: begin
            mul_req.start = !pend_ff;
            mul_req.a     = gain_rd;
            mul_req.b     = xtp_ff[j_ff];
         end
         default: ;
      endcase

      div_req.neg = num[FX_W-1];
      if (state_ff == ST_GAIN) begin
         div_req.start    = !pend_ff && !den_bad;
         div_req.round_en = 1'b1;
         div_req.dividend = {num_mag, {FRAC{1'b0}}};
         div_req.divisor  = den_ff;
         div_req.iters    = GAIN_ITERS;
      end else begin
         div_req.start    = !pend_ff && (state_ff == ST_PUPD_DIV);
         div_req.round_en = 1'b0;
         div_req.dividend = {lam_dvd, {(DVD_W-LAM_DVD_W){1'b0}}};
         div_req.divisor  = DVS_W'(lam);
         div_req.iters    = LAM_ITERS;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_ERR_MAC;
         ST_ERR_MAC:  if (mul_rsp.done && j_last) state_in = ST_ERR;
         ST_ERR:      state_in = ST_PX;
         ST_PX:       if (mul_rsp.done && j_last && i_last) state_in = ST_XTP;
         ST_XTP:      if (mul_rsp.done && j_last && i_last) state_in = ST_DEN;
         ST_DEN:      if (mul_rsp.done && j_last) state_in = ST_GAIN;
         ST_GAIN: begin
            if (den_bad || (div_rsp.done && j_last)) state_in = ST_COEF;
         end
         ST_COEF:     if (mul_rsp.done && j_last) state_in = ST_EST_MAC;
         ST_EST_MAC:  if (mul_rsp.done && j_last) state_in = ST_EST;
         ST_EST:      state_in = ST_PUPD_MUL;
         ST_PUPD_MUL: if (mul_rsp.done) state_in = ST_PUPD_DIV;
         ST_PUPD_DIV: begin
            if (div_rsp.done) state_in = (i_last && j_last) ? ST_DONE : ST_PUPD_MUL;
         end
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         forget_ff     <= FORGET_RST;
         init_cov_ff   <= INIT_COV_RST;
         fill_ff       <= '0;
         pend_ff       <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int k = 0; k < ORDER; k++) window_ff[k] <= '0;
         for (int k = 0; k < DIM; k++) begin
            coef_ff[k] <= '0;
            for (int m = 0; m < DIM; m++) begin
               cov_ff[k][m] <= (k == m) ? {8'd0, INIT_COV_RST, {FRAC{1'b0}}} : '0;
            end
         end
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               CSR_FORGET:   forget_ff   <= csr_wdata;
               CSR_INIT_COV: init_cov_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (mul_req.start || div_req.start) pend_ff <= 1'b1;
         if (mul_rsp.done || div_rsp.done) pend_ff <= 1'b0;

         if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;

         if ((mul_rsp.done && state_ff != ST_PUPD_MUL) || div_rsp.done) begin
            if (j_last) begin
               j_ff <= '0;
               i_ff <= i_last ? '0 : i_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  sample_ff <= $signed(req_tdata);
                  sat_ff    <= 1'b0;
                  acc_ff    <= '0;
                  i_ff      <= '0;
                  j_ff      <= '0;
                  fill_ff   <= fill_in;
                  for (int k = 0; k < ORDER; k++) window_ff[k] <= window_in[k];
                  if (req_tuser[0]) begin
                     for (int k = 0; k < DIM; k++) begin
                        coef_ff[k] <= '0;
                        for (int m = 0; m < DIM; m++) begin
                           cov_ff[k][m] <= (k == m) ?
                              {8'd0, init_cov_ff, {FRAC{1'b0}}} : '0;
                        end
                     end
                  end
               end
            end
            ST_ERR_MAC, ST_EST_MAC: begin
               if (mul_rsp.done) acc_ff <= sum;
            end
            ST_ERR: begin
               err_ff <= sat24(err_full);
               if (ovf24(err_full)) sat_ff <= 1'b1;
               acc_ff <= '0;
               i_ff   <= '0;
            end
            ST_PX, ST_XTP: begin
               if (mul_rsp.done) begin
                  if (j_last) begin
                     if (state_ff == ST_PX) px_ff[i_ff] <= sat48(sum);
                     else xtp_ff[i_ff] <= sat48(sum);
                     if (ovf48(sum)) sat_ff <= 1'b1;
                     acc_ff <= '0;
                  end else begin
                     acc_ff <= sum;
                  end
               end
            end
            ST_DEN: begin
               if (mul_rsp.done) begin
                  if (j_last) begin
                     den_ff <= sum + ACC_W'({lam, 8'd0});
                     acc_ff <= '0;
                  end else begin
                     acc_ff <= sum;
                  end
               end
            end
            ST_GAIN: begin
               if (den_bad) begin
                  for (int k = 0; k < DIM; k++) gain_ff[k] <= '0;
                  sat_ff <= 1'b1;
               end else if (div_rsp.done) begin
                  gain_ff[j_ff] <= div_rsp.quot;
                  if (div_rsp.sat) sat_ff <= 1'b1;
               end
            end
            ST_COEF: begin
               if (mul_rsp.done) begin
                  coef_ff[j_ff] <= sat48(c_add);
                  if (ovf48(c_add)) sat_ff <= 1'b1;
               end
            end
            ST_EST: begin
               est_ff <= sat24(rnd_acc);
               if (ovf24(rnd_acc)) sat_ff <= 1'b1;
               acc_ff <= '0;
               i_ff   <= '0;
               j_ff   <= '0;
            end
            ST_PUPD_MUL: begin
               if (mul_rsp.done) begin
                  pdiff_ff <= sat48(p_sub);
                  if (ovf48(p_sub)) sat_ff <= 1'b1;
               end
            end
            ST_PUPD_DIV: begin
               if (div_rsp.done) begin
                  cov_ff[i_ff][j_ff] <= div_rsp.quot;
                  if (div_rsp.sat) sat_ff <= 1'b1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {err_ff, est_ff};
                  rsp_tuser_ff  <= sat_ff;
               end
            end
            default: ;
         endcase
      end
   end

   a_mul_done_pend: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> pend_ff)
      else $error("multiplier result without an issued product");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_ERR_MAC))
      else $error("accepted beat did not start the sequence");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(ORDER))
      else $error("window fill count out of range");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == ST_DONE))
      else $error("result dropped while response stalled");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rls_pkg::*;

   typedef struct {
      logic [SMP_W-1:0] smp;
      logic             rst;
   } sample_beat_t;

   typedef struct {
      logic [SMP_W-1:0] est;
      logic [SMP_W-1:0] err;
      logic             sat;
   } estimate_beat_t;

   localparam longint ONE_FX  = 64'sd16777216;
   localparam longint HI_CLIP = 64'sd67108864;
   localparam longint MAX_48  = (64'sd1 <<< 47) - 1;
   localparam longint MIN_48  = -(64'sd1 <<< 47);
   localparam int     WATCHDOG_LIMIT = 40000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SMP_W-1:0]     req_tdata = '0;
   logic [0:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*SMP_W-1:0]   rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FORGET;
   logic [LAM_W-1:0]     csr_wdata = '0;

   rls_sample_predictor dut (.*);

   always #2 clock = ~clock;

   sample_beat_t   sample_queue[$];
   estimate_beat_t estimate_queue[$];
   int             errors = 0;
   int             idle_cycles = 0;
   logic           req_taken = 1'b0;
   int             req_gap = 0;
   int             rsp_hold = 0;
   logic           steady_mode = 1'b0;
   logic           long_hold_due = 1'b0;

   // predictor state
   logic [LAM_W-1:0] lam_q;
   logic [LAM_W-1:0] cov_init_q;
   longint           win[ORDER];
   int               fill;
   longint           coef[DIM];
   longint           pcov[DIM][DIM];
   logic             clipped;

   function automatic longint clip48(longint v);
      if (v > MAX_48) begin
         clipped = 1'b1;
         return MAX_48;
      end
      if (v < MIN_48) begin
         clipped = 1'b1;
         return MIN_48;
      end
      return v;
   endfunction

   function automatic longint clip24(longint v);
      if (v > 64'sd8388607) begin
         clipped = 1'b1;
         return 64'sd8388607;
      end
      if (v < -64'sd8388608) begin
         clipped = 1'b1;
         return -64'sd8388608;
      end
      return v;
   endfunction

   function automatic longint fx_product(longint a, longint b);
      longint unsigned al, bl, lo;
      longint ah, bh, hi, mid;
      al = a & 64'hFFFFFF;
      bl = b & 64'hFFFFFF;
      ah = a >>> 24;
      bh = b >>> 24;
      hi = ah * bh;
      if (hi > HI_CLIP) return HI_CLIP * ONE_FX;
      if (hi < -HI_CLIP) return -HI_CLIP * ONE_FX;
      mid = ah * longint'(bl) + bh * longint'(al);
      lo = (al * bl + 64'd8388608) >> 24;
      return hi * ONE_FX + mid + longint'(lo);
   endfunction

   function automatic longint gain_quotient(longint n, longint d);
      logic neg, big;
      longint unsigned mag, ud, q, r, lim;
      neg = n < 0;
      mag = neg ? longint'(-n) : n;
      ud = d;
      q = mag / ud;
      r = mag % ud;
      lim = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
      big = 1'b0;
      for (int i = 0; i < 24; i++) begin
         if (q >= (64'd1 << 48)) begin
            big = 1'b1;
            break;
         end
         q = q << 1;
         r = r << 1;
         if (r >= ud) begin
            r = r - ud;
            q = q | 64'd1;
         end
      end
      if (!big && 2 * r >= ud) q = q + 1;
      if (big || q > lim) begin
         clipped = 1'b1;
         q = lim;
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint lambda_quotient(longint v, longint unsigned lam);
      logic neg;
      longint unsigned mag, lim, q;
      neg = v < 0;
      mag = neg ? longint'(-v) : v;
      lim = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
      q = ((mag << 16) + (lam >> 1)) / lam;
      if (q > lim) begin
         clipped = 1'b1;
         q = lim;
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic void clear_history();
      for (int i = 0; i < ORDER; i++) win[i] = 0;
      fill = 0;
      for (int i = 0; i < DIM; i++) begin
         coef[i] = 0;
         for (int j = 0; j < DIM; j++)
            pcov[i][j] = (i == j) ? longint'(cov_init_q) * ONE_FX : 0;
      end
   endfunction

   function automatic estimate_beat_t predict_estimate(sample_beat_t b);
      longint x[DIM], px[DIM], xtp[DIM], g[DIM];
      longint smp, acc, den, err, est, s1, s2;
      longint unsigned lam;
      estimate_beat_t r;
      smp = longint'(signed'(b.smp));
      lam = (lam_q == 0) ? 1 : lam_q;
      clipped = 1'b0;
      if (b.rst) clear_history();
      if (fill < ORDER) begin
         win[fill] = smp;
         fill++;
      end else begin
         for (int i = 0; i + 1 < ORDER; i++) win[i] = win[i+1];
         win[ORDER-1] = smp;
      end
      x[0] = ONE_FX;
      for (int j = 1; j < DIM; j++) x[j] = (j <= fill) ? win[j-1] * 16 : 0;
      acc = 0;
      for (int j = 0; j < DIM; j++) acc += fx_product(coef[j], x[j]);
      err = clip24(smp - ((acc + 8) >>> 4));
      for (int i = 0; i < DIM; i++) begin
         s1 = 0;
         s2 = 0;
         for (int j = 0; j < DIM; j++) begin
            s1 += fx_product(pcov[i][j], x[j]);
            s2 += fx_product(x[j], pcov[j][i]);
         end
         px[i] = clip48(s1);
         xtp[i] = clip48(s2);
      end
      den = longint'(lam) * 256;
      for (int j = 0; j < DIM; j++) den += fx_product(xtp[j], x[j]);
      if (den <= 0) begin
         clipped = 1'b1;
         for (int i = 0; i < DIM; i++) g[i] = 0;
      end else begin
         for (int i = 0; i < DIM; i++) g[i] = gain_quotient(px[i], den);
      end
      for (int i = 0; i < DIM; i++)
         coef[i] = clip48(coef[i] + fx_product(g[i], err * 16));
      acc = 0;
      for (int j = 0; j < DIM; j++) acc += fx_product(coef[j], x[j]);
      est = clip24((acc + 8) >>> 4);
      for (int i = 0; i < DIM; i++)
         for (int j = 0; j < DIM; j++)
            pcov[i][j] = lambda_quotient(clip48(pcov[i][j] - fx_product(g[i], xtp[j])), lam);
      r.est = est[SMP_W-1:0];
      r.err = err[SMP_W-1:0];
      r.sat = clipped;
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 300);
   endfunction

   // driver
   always @(negedge clock) begin
      sample_beat_t b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            b = sample_queue.pop_front();
            req_tdata <= b.smp;
            req_tuser <= b.rst;
            req_tvalid <= 1'b1;
            if (!steady_mode) req_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_due) begin
         long_hold_due = 1'b0;
         rsp_hold <= 12000;
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady_mode) rsp_hold <= pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      estimate_beat_t e;
      sample_beat_t b;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
         end
         if (req_tvalid && req_tready) begin
            b.smp = req_tdata;
            b.rst = req_tuser[0];
            estimate_queue.push_back(predict_estimate(b));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (estimate_queue.size() == 0) begin
               $error("unexpected beat estimate=%h pred_error=%h", rsp_tdata[23:0],
                      rsp_tdata[47:24]);
               errors++;
            end else begin
               e = estimate_queue.pop_front();
               if (rsp_tdata[23:0] !== e.est) begin
                  $error("estimate expected %h actual %h", e.est, rsp_tdata[23:0]);
                  errors++;
               end
               if (rsp_tdata[47:24] !== e.err) begin
                  $error("pred_error expected %h actual %h", e.err, rsp_tdata[47:24]);
                  errors++;
               end
               if (rsp_tuser[0] !== e.sat) begin
                  $error("saturated expected %b actual %b", e.sat, rsp_tuser[0]);
                  errors++;
               end
            end
         end
      end
   end

   task automatic add_sample(logic [SMP_W-1:0] smp, logic rst);
      sample_beat_t b;
      b.smp = smp;
      b.rst = rst;
      sample_queue.push_back(b);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [LAM_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FORGET) lam_q = val;
      else cov_init_q = val;
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || req_tvalid || estimate_queue.size() > 0)
         @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   function automatic logic [SMP_W-1:0] random_sample();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return SMP_W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      if (p < 85) return SMP_W'($urandom);
      if (p < 92) return MAX24;
      if (p < 99) return MIN24;
      return '0;
   endfunction

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) steady_mode = ($urandom_range(0, 3) == 0);
         add_sample(random_sample(), ($urandom_range(0, 49) == 0));
      end
   endtask

   initial begin
      lam_q = FORGET_RST;
      cov_init_q = INIT_COV_RST;
      clear_history();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      add_sample(MAX24, 1'b1);
      add_sample(MAX24, 1'b0);
      add_sample(MIN24, 1'b0);
      add_sample(MIN24, 1'b0);
      add_sample(MAX24, 1'b0);
      add_sample('0, 1'b0);
      add_sample(24'd1, 1'b1);
      add_sample(24'hFFFFFF, 1'b0);
      add_sample(24'h100000, 1'b0);
      add_sample(24'h100000, 1'b0);
      add_sample(24'h100000, 1'b0);
      add_sample(24'h100000, 1'b0);
      add_sample(24'h100000, 1'b0);
      add_sample(24'h555555, 1'b1);
      add_sample(24'hAAAAAA, 1'b0);
      add_sample(MIN24, 1'b1);
      random_run(100);
      drain();

      write_csr(CSR_FORGET, 16'hFFFF);
      write_csr(CSR_INIT_COV, 16'd1);
      add_sample(24'h012345, 1'b1);
      long_hold_due = 1'b1;
      random_run(120);
      drain();

      write_csr(CSR_FORGET, 16'd32768);
      write_csr(CSR_INIT_COV, 16'hFFFF);
      add_sample(MAX24, 1'b1);
      random_run(110);
      drain();

      write_csr(CSR_FORGET, 16'd0);
      write_csr(CSR_INIT_COV, 16'd0);
      add_sample(24'h0FFFFF, 1'b1);
      random_run(60);
      drain();

      write_csr(CSR_FORGET, 16'd60000);
      write_csr(CSR_INIT_COV, 16'd100);
      add_sample('0, 1'b1);
      random_run(110);
      drain();

      for (int k = 0; k < 3; k++) begin
         write_csr(CSR_FORGET, LAM_W'($urandom_range(32768, 65535)));
         write_csr(CSR_INIT_COV, LAM_W'($urandom_range(1, 65535)));
         add_sample(random_sample(), 1'b1);
         random_run(80);
         drain();
      end

      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rls_pkg.sv
design/rls_fxmul.sv
design/rls_div.sv
design/rls_sample_predictor.sv
tb/tb.sv
